// ----- design/serpentine_run_stroke_planner_top_defines.svh -----
// assertion macros for the serpentine run stroke planner checker
`ifndef SERPENTINE_RUN_STROKE_PLANNER_TOP_DEFINES_SVH
`define SERPENTINE_RUN_STROKE_PLANNER_TOP_DEFINES_SVH

// implication checked in the next cycle, off while reset is high
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// property that holds at every edge, reset included
`define SRS_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) (expr)) else $error(msg);

`endif

// ----- design/srs_pkg.sv -----
// shared types and constants of the serpentine run stroke planner
`default_nettype none

package srs_pkg;

   // field widths fixed by the item formats
   localparam int COL_W  = 6;
   localparam int ROW_W  = 12;
   localparam int PEN_W  = 16;
   localparam int CFG_W  = 7;
   localparam int STEP_W = 8;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_WIDTH      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STEP       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN_LENGTH = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_STEP     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEN_CODE       = 3'd4;

   // input item
   typedef struct packed {
      logic pixel_on;
      logic mask_start;
   } req_item_type;

   // result item
   typedef struct packed {
      logic [COL_W-1:0] point_x;
      logic [ROW_W-1:0] point_y;
      logic [PEN_W-1:0] pen;
      logic             last_point;
   } rsp_item_type;

   // one kept run, handed from the scanner to the stroke emitter
   typedef struct packed {
      logic [COL_W-1:0] x0;
      logic [COL_W-1:0] x1;
      logic             reverse;
      logic [ROW_W-1:0] y;
      logic [PEN_W-1:0] pen;
   } run_desc_type;

   // queue status seen by the scanner
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   // stroke emitter states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_STEP,
      BK_TAIL
   } back_state_type;

endpackage

`default_nettype wire

// ----- design/serpentine_run_stroke_planner_top.sv -----
// top level of the serpentine run stroke planner
//
//   channel   direction  ports                                  item
//   req       in         req_valid req_ready req_data           one mask pixel
//   rsp       out        rsp_valid rsp_ready rsp_data           one stroke point
//   csr       in         csr_valid csr_ready csr_index csr_data register write
//
// the scanner takes one pixel per cycle while the run queue has room
// a kept run leaves the emitter as one point per cycle while rsp_ready is high,
// once the emitter has loaded it from the queue; the emitter sets the rate
// the four-entry run queue lets the scanner run ahead while points are stalled
// synchronous reset clears position, direction, queue and output valid
// csr writes are taken every cycle
`default_nettype none

module serpentine_run_stroke_planner_top #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 4096
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire srs_pkg::req_item_type             req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output srs_pkg::rsp_item_type                  rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [srs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [srs_pkg::CSR_DAT_W-1:0]     csr_data
);

   logic [srs_pkg::CFG_W-1:0]   row_width_ff;
   logic [srs_pkg::STEP_W-1:0]  row_step_ff;
   logic [srs_pkg::CFG_W-1:0]   min_run_length_ff;
   logic [srs_pkg::CFG_W-1:0]   point_step_ff;
   logic [srs_pkg::PEN_W-1:0]   pen_code_ff;

   logic                        req_accept;
   logic                        push;
   logic                        pop;
   srs_pkg::run_desc_type       push_desc;
   srs_pkg::run_desc_type       head;
   srs_pkg::queue_stat_type     stat;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff      <= srs_pkg::CFG_W'(64);
         row_step_ff       <= srs_pkg::STEP_W'(1);
         min_run_length_ff <= srs_pkg::CFG_W'(1);
         point_step_ff     <= srs_pkg::CFG_W'(1);
         pen_code_ff       <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            srs_pkg::CSR_ROW_WIDTH:      row_width_ff      <= csr_data[srs_pkg::CFG_W-1:0];
            srs_pkg::CSR_ROW_STEP:       row_step_ff       <= csr_data[srs_pkg::STEP_W-1:0];
            srs_pkg::CSR_MIN_RUN_LENGTH: min_run_length_ff <= csr_data[srs_pkg::CFG_W-1:0];
            srs_pkg::CSR_POINT_STEP:     point_step_ff     <= csr_data[srs_pkg::CFG_W-1:0];
            srs_pkg::CSR_PEN_CODE:       pen_code_ff       <= csr_data[srs_pkg::PEN_W-1:0];
            default: ;
         endcase
      end
   end

   // input handshake, held off while the run queue is full
   assign req_ready  = !stat.full;
   assign req_accept = req_valid && req_ready;

   srs_scan #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_accept),
      .item           (req_data),
      .row_width      (row_width_ff),
      .row_step       (row_step_ff),
      .min_run_length (min_run_length_ff),
      .pen_code       (pen_code_ff),
      .push           (push),
      .push_desc      (push_desc)
   );

   srs_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .stat      (stat)
   );

   srs_stroke u_stroke (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .stat       (stat),
      .pop        (pop),
      .point_step (point_step_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- design/srs_scan.sv -----
// front end: tracks raster position, finds kept runs and queues them
`default_nettype none

module srs_scan #(
   parameter int MAX_COLS = 64,
   parameter int MAX_ROWS = 4096
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire srs_pkg::req_item_type         item,
   input  wire logic [srs_pkg::CFG_W-1:0]     row_width,
   input  wire logic [srs_pkg::STEP_W-1:0]    row_step,
   input  wire logic [srs_pkg::CFG_W-1:0]     min_run_length,
   input  wire logic [srs_pkg::PEN_W-1:0]     pen_code,
   output logic                               push,
   output srs_pkg::run_desc_type              push_desc
);

   localparam int COLS_BITS = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROWS_BITS = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [srs_pkg::CFG_W-1:0] MAX_COLS_V = srs_pkg::CFG_W'(MAX_COLS);
   localparam logic [ROWS_BITS-1:0] LAST_ROW = ROWS_BITS'(MAX_ROWS - 1);

   logic [COLS_BITS-1:0]        column_ff, column_in;
   logic [ROWS_BITS-1:0]        row_ff, row_in;
   logic [srs_pkg::COL_W-1:0]   run_start_ff, run_start_in;
   logic                        in_run_ff, in_run_in;
   logic                        reverse_ff, reverse_in;
   logic [srs_pkg::STEP_W-1:0]  phase_ff, phase_in;

   logic [COLS_BITS-1:0]        col;
   logic [ROWS_BITS-1:0]        row;
   logic [srs_pkg::STEP_W-1:0]  phase;
   logic                        in_run;
   logic                        reverse;
   logic [srs_pkg::COL_W-1:0]   col6;
   logic [srs_pkg::CFG_W-1:0]   width_eff;
   logic                        last_col;
   logic                        emit;
   logic [srs_pkg::COL_W-1:0]   x0;
   logic [srs_pkg::COL_W-1:0]   x1;
   logic [srs_pkg::CFG_W-1:0]   run_len;
   logic                        keep;
   logic [srs_pkg::STEP_W:0]    phase_inc;

   // position as seen by this pixel, cleared on a new mask
   always_comb begin
      col     = item.mask_start ? '0 : column_ff;
      row     = item.mask_start ? '0 : row_ff;
      phase   = item.mask_start ? '0 : phase_ff;
      in_run  = item.mask_start ? 1'b0 : in_run_ff;
      reverse = item.mask_start ? 1'b0 : reverse_ff;
      col6    = srs_pkg::COL_W'(col);
   end

   // effective row width and end of row
   always_comb begin
      if (row_width == '0) begin
         width_eff = srs_pkg::CFG_W'(1);
      end else if (row_width > MAX_COLS_V) begin
         width_eff = MAX_COLS_V;
      end else begin
         width_eff = row_width;
      end
      last_col = ({1'b0, col6} + srs_pkg::CFG_W'(1)) >= width_eff;
   end

   // run detection in scanned rows
   always_comb begin
      emit         = 1'b0;
      x0           = run_start_ff;
      x1           = col6;
      run_start_in = run_start_ff;
      if (phase == '0) begin
         if (item.pixel_on) begin
            if (!in_run) begin
               run_start_in = col6;
               x0           = col6;
            end
            emit = last_col;
         end else if (in_run) begin
            emit = 1'b1;
            x1   = col6 - srs_pkg::COL_W'(1);
         end
      end
      run_len = {1'b0, x1} - {1'b0, x0} + srs_pkg::CFG_W'(1);
      keep    = emit && (run_len >= min_run_length);
   end

   // queue write
   always_comb begin
      push              = accept && keep;
      push_desc.x0      = x0;
      push_desc.x1      = x1;
      push_desc.reverse = reverse;
      push_desc.y       = srs_pkg::ROW_W'(row);
      push_desc.pen     = pen_code;
   end

   // next position and run state
   always_comb begin
      phase_inc  = {1'b0, phase} + (srs_pkg::STEP_W + 1)'(1);
      reverse_in = keep ? !reverse : reverse;
      if (phase == '0) begin
         in_run_in = item.pixel_on;
      end else begin
         in_run_in = in_run;
      end
      if (last_col) begin
         column_in = '0;
         in_run_in = 1'b0;
         row_in    = (row == LAST_ROW) ? '0 : row + ROWS_BITS'(1);
         if (row_step <= srs_pkg::STEP_W'(1) || phase_inc >= {1'b0, row_step}) begin
            phase_in = '0;
         end else begin
            phase_in = phase_inc[srs_pkg::STEP_W-1:0];
         end
      end else begin
         column_in = col + COLS_BITS'(1);
         row_in    = row;
         phase_in  = phase;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         run_start_ff <= '0;
         in_run_ff    <= 1'b0;
         reverse_ff   <= 1'b0;
         phase_ff     <= '0;
      end else if (accept) begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         run_start_ff <= run_start_in;
         in_run_ff    <= in_run_in;
         reverse_ff   <= reverse_in;
         phase_ff     <= phase_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/srs_queue.sv -----
// four-entry queue of run descriptors between scanner and emitter
`default_nettype none

module srs_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire srs_pkg::run_desc_type   push_desc,
   input  wire logic                    pop,
   output srs_pkg::run_desc_type        head,
   output srs_pkg::queue_stat_type      stat
);

   localparam int DEPTH = 4;
   localparam int PTR_W = $clog2(DEPTH);

   srs_pkg::run_desc_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // status and pointer updates
   always_comb begin
      stat.full  = count_ff == (PTR_W + 1)'(DEPTH);
      stat.empty = count_ff == '0;
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      wr_ptr_in  = do_push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in  = do_pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + (PTR_W + 1)'(1);
         2'b01:   count_in = count_ff - (PTR_W + 1)'(1);
         default: count_in = count_ff;
      endcase
      head = entries_ff[rd_ptr_ff];
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_desc;
      end
   end

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/srs_stroke.sv -----
// back end: walks one queued run and emits its stroke points
`default_nettype none

module srs_stroke (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire srs_pkg::run_desc_type       head,
   input  wire srs_pkg::queue_stat_type     stat,
   output logic                             pop,
   input  wire logic [srs_pkg::CFG_W-1:0]   point_step,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output srs_pkg::rsp_item_type            rsp_data
);

   srs_pkg::back_state_type     state_ff, state_in;
   srs_pkg::run_desc_type       desc_ff, desc_in;
   logic [srs_pkg::CFG_W-1:0]   off_ff, off_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   srs_pkg::rsp_item_type       rsp_data_ff, rsp_data_in;

   logic                        advance;
   logic [srs_pkg::CFG_W-1:0]   step;
   logic [srs_pkg::CFG_W-1:0]   run_len;
   logic [srs_pkg::CFG_W:0]     next_off;
   logic [srs_pkg::CFG_W-1:0]   pos;
   logic [srs_pkg::COL_W-1:0]   far_end;

   // point position along the current run
   always_comb begin
      advance  = !rsp_valid_ff || rsp_ready;
      step     = (point_step == '0) ? srs_pkg::CFG_W'(1) : point_step;
      run_len  = {1'b0, desc_ff.x1} - {1'b0, desc_ff.x0} + srs_pkg::CFG_W'(1);
      next_off = {1'b0, off_ff} + {1'b0, step};
      if (desc_ff.reverse) begin
         pos = {1'b0, desc_ff.x1} - off_ff;
      end else begin
         pos = {1'b0, desc_ff.x0} + off_ff;
      end
      far_end = desc_ff.reverse ? desc_ff.x0 : desc_ff.x1;
   end

   // emitter sequencing and output register load
   always_comb begin
      state_in     = state_ff;
      desc_in      = desc_ff;
      off_in       = off_ff;
      pop          = 1'b0;
      rsp_valid_in = advance ? 1'b0 : rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         srs_pkg::BK_IDLE: begin
            if (!stat.empty) begin
               pop      = 1'b1;
               desc_in  = head;
               off_in   = '0;
               state_in = srs_pkg::BK_STEP;
            end
         end
         srs_pkg::BK_STEP: begin
            if (advance) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.point_x    = pos[srs_pkg::COL_W-1:0];
               rsp_data_in.point_y    = desc_ff.y;
               rsp_data_in.pen        = desc_ff.pen;
               rsp_data_in.last_point = 1'b0;
               if (next_off >= {1'b0, run_len}) begin
                  if (off_ff == run_len - srs_pkg::CFG_W'(1)) begin
                     rsp_data_in.last_point = 1'b1;
                     state_in               = srs_pkg::BK_IDLE;
                  end else begin
                     state_in = srs_pkg::BK_TAIL;
                  end
               end else begin
                  off_in = next_off[srs_pkg::CFG_W-1:0];
               end
            end
         end
         srs_pkg::BK_TAIL: begin
            if (advance) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.point_x    = far_end;
               rsp_data_in.point_y    = desc_ff.y;
               rsp_data_in.pen        = desc_ff.pen;
               rsp_data_in.last_point = 1'b1;
               state_in               = srs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = srs_pkg::BK_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= srs_pkg::BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      desc_ff     <= desc_in;
      off_ff      <= off_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- design/srs_checker.sv -----
// port-level checks of the serpentine run stroke planner, bound to the top level
`default_nettype none
`include "serpentine_run_stroke_planner_top_defines.svh"

module srs_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire srs_pkg::rsp_item_type  rsp_data
);

   // a stalled point holds
   `SRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "stalled point changed")

   // no point shows right after reset
   `SRS_ASSERT_ALWAYS(a_reset_quiet, $past(reset) !== 1'b1 || rsp_valid === 1'b0, "point valid after reset")

   // points of one stroke follow without a gap
   `SRS_ASSERT_NEXT(a_stroke_gapless, rsp_valid && rsp_ready && !rsp_data.last_point, rsp_valid, "gap inside a stroke")

   // a stroke stays on one row with one pen
   `SRS_ASSERT_NEXT(a_stroke_same_row, rsp_valid && rsp_ready && !rsp_data.last_point, rsp_data.point_y == $past(rsp_data.point_y) && rsp_data.pen == $past(rsp_data.pen), "stroke changed row or pen")

endmodule

bind serpentine_run_stroke_planner_top srs_checker u_srs_checker (.*);

`default_nettype wire
